@@ src/stlru_pkg.sv @@
// shared types and constants for the station table with lru replacement
`default_nettype none

package stlru_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W  = 48;
    localparam int IP_W    = 32;
    localparam int TIME_W  = 64;
    localparam int REPLY_W = 32;

    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int OCC_W    = 5;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    localparam logic [7:0] MCAST_FIRST_OCTET = 8'd224;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [IP_W-1:0]    ip;
        logic [TIME_W-1:0]  last_seen;
        logic [REPLY_W-1:0] replies;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } wr_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [REPLY_W-1:0]  reply_total;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

endpackage

`default_nettype wire

@@ src/stlru_table.sv @@
// station table storage: per-entry valid bits and entry registers, one read and one write port
`default_nettype none

module stlru_table
    import stlru_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_entry,
    output logic                  rd_valid,
    input  wire wr_t              wr
);

    logic [TABLE_DEPTH-1:0] valid_reg;
    entry_t                 entry_reg [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    // payload needs no reset, an invalid entry is never used
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_entry = entry_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

endmodule

`default_nettype wire

@@ src/stlru_seq.sv @@
// sequencer: filter check, one-entry-per-cycle table scan with a shared compare, commit
`default_nettype none

module stlru_seq
    import stlru_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    output logic                     idle,
    input  wire logic [ADDR_W-1:0]   in_addr,
    input  wire logic [IP_W-1:0]     in_ip,
    input  wire logic [TIME_W-1:0]   in_now,
    input  wire logic [ADDR_W-1:0]   local_identity,
    input  wire logic                out_free,
    output logic                     res_valid,
    output result_t                  res,
    output logic [IDX_W-1:0]         rd_idx,
    input  wire entry_t              rd_entry,
    input  wire logic                rd_valid,
    output wr_t                      wr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    state_t             state_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               reject_reg;
    logic               hit_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic [TIME_W-1:0]  min_last_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [REPLY_W-1:0] hit_replies_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               unicast;
    logic               group_ok;
    logic               older;
    logic [TIME_W-1:0]  cmp_a;
    logic [TIME_W-1:0]  cmp_b;
    logic               drop;
    logic [IDX_W-1:0]   ins_idx;
    logic [CNT_W-1:0]   count_next;
    logic [REPLY_W-1:0] replies_next;

    assign unicast = (ip_reg != '0) && (ip_reg != '1) && (ip_reg[31:24] != 8'd0)
                   && (ip_reg[31:24] < MCAST_FIRST_OCTET);
    assign group_ok = (addr_reg[39:24] == local_identity[39:24]);

    // shared 64-bit less-than: last-seen vs running minimum while scanning,
    // then now vs last-seen of the hit entry at commit
    always_comb begin
        if (state_reg == S_SCAN) begin
            cmp_a = rd_entry.last_seen;
            cmp_b = min_last_reg;
        end else begin
            cmp_a = now_reg;
            cmp_b = min_last_reg;
        end
    end
    assign older = (cmp_a < cmp_b);

    assign drop         = reject_reg || (hit_reg && older);
    assign ins_idx      = free_found_reg ? free_idx_reg : min_idx_reg;
    assign count_next   = (count_reg < FULL_CNT) ? count_reg + 1'b1 : count_reg;
    assign replies_next = (hit_replies_reg == '1) ? hit_replies_reg
                                                  : hit_replies_reg + 1'b1;

    assign idle      = (state_reg == S_IDLE);
    assign rd_idx    = idx_reg;
    assign res_valid = (state_reg == S_COMMIT) && out_free;

    always_comb begin
        res            = '0;
        wr             = '0;
        wr.data.addr   = addr_reg;
        wr.data.ip     = ip_reg;
        wr.data.last_seen = now_reg;
        wr.data.replies   = replies_next;
        wr.idx         = hit_idx_reg;
        res.occupancy  = OCC_W'(count_reg);
        if (drop) begin
            res.status = ST_REJECTED;
        end else if (hit_reg) begin
            res.status      = ST_UPDATED;
            res.slot        = SLOT_W'(hit_idx_reg);
            res.reply_total = replies_next;
            wr.en           = res_valid;
        end else begin
            res.status      = ST_INSERTED;
            res.slot        = SLOT_W'(ins_idx);
            res.evicted     = !free_found_reg;
            res.reply_total = REPLY_W'(1);
            res.occupancy   = OCC_W'(count_next);
            wr.idx          = ins_idx;
            wr.data.replies = REPLY_W'(1);
            wr.en           = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        addr_reg  <= in_addr;
                        ip_reg    <= in_ip;
                        now_reg   <= in_now;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    reject_reg     <= !(unicast && group_ok);
                    hit_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                    idx_reg        <= '0;
                    state_reg      <= (unicast && group_ok) ? S_SCAN : S_COMMIT;
                end
                S_SCAN: begin
                    if (rd_valid && (rd_entry.addr == addr_reg)) begin
                        hit_reg         <= 1'b1;
                        hit_idx_reg     <= idx_reg;
                        hit_replies_reg <= rd_entry.replies;
                        min_last_reg    <= rd_entry.last_seen;
                        state_reg       <= S_COMMIT;
                    end else begin
                        if (!rd_valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        // strict less keeps the lowest index on ties
                        if ((idx_reg == '0) || older) begin
                            min_last_reg <= rd_entry.last_seen;
                            min_idx_reg  <= idx_reg;
                        end
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= S_COMMIT;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (out_free) begin
                        if (!drop && !hit_reg) begin
                            count_reg <= count_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/station_table_lru_update_core.sv @@
// top level: stream ports, identity register, output register, sequencer and table
`default_nettype none

// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata: station_address, source_ip, now_ms
// m_        out  m_tvalid / m_tready    m_tdata: status, slot, evicted, reply_total, occupancy
// cfg_      in   cfg_valid / cfg_ready  cfg_data: local_identity
//
// a reply that is filtered out goes from the check step straight to the commit step; otherwise
// the check step is followed by a scan of one table entry per cycle through the shared compare
// (up to 16), then the commit step. input is taken only while the sequencer is idle.
// a result waits in the output register; the next reply is accepted meanwhile,
// and its commit stalls only while the previous result is still not taken.
// reset clears valid bits, occupancy, identity and the handshakes; no clearing pass.

module station_table_lru_update_core
    import stlru_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,   // station_address[47:0], source_ip[79:48], now_ms[143:80]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // status[1:0], slot[5:2], evicted[6],
                                         // reply_total[38:7], occupancy[43:39], zero[47:44]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [47:0]  cfg_data   // local_identity[47:0]
);

    logic [ADDR_W-1:0] identity_reg;
    logic              m_tvalid_reg;
    result_t           m_result_reg;

    logic              idle;
    logic              out_free;
    logic              res_valid;
    result_t           res;
    logic [IDX_W-1:0]  rd_idx;
    entry_t            rd_entry;
    logic              rd_valid;
    wr_t               wr;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            identity_reg <= '0;
        end else if (cfg_valid) begin
            identity_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_result_reg.occupancy, m_result_reg.reply_total,
                       m_result_reg.evicted, m_result_reg.slot, m_result_reg.status};

    stlru_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (s_tvalid && s_tready),
        .idle           (idle),
        .in_addr        (s_tdata[47:0]),
        .in_ip          (s_tdata[79:48]),
        .in_now         (s_tdata[143:80]),
        .local_identity (identity_reg),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res),
        .rd_idx         (rd_idx),
        .rd_entry       (rd_entry),
        .rd_valid       (rd_valid),
        .wr             (wr)
    );

    stlru_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr       (wr)
    );

endmodule

`default_nettype wire
